// File: hw/rtl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 decoder: the run
// descriptor that travels from the classifier to the unit emitter, and the
// queue geometry.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam logic [15:0] REPL_UNIT = 16'hFFFD;

  // Queue between classifier and emitter; depth must be a power of two
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // What follows the replacement units of one run
  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_ONE  = 2'd1,
    TAIL_PAIR = 2'd2
  } tail_t;

  // One byte's worth of output: n_repl times U+FFFD, then the tail units
  typedef struct packed {
    logic [2:0]  n_repl;
    tail_t       tail;
    logic [15:0] unit0;
    logic [15:0] unit1;
  } run_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: hw/rtl/u8u16_in_if.sv
// ----------------------------------------------------------------------------
// u8u16_in_if
// Byte request channel: one raw UTF-8 byte and an end-of-input flag.
// ----------------------------------------------------------------------------
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_input;

  modport source (output valid, output byte_in, output end_of_input, input ready);
  modport sink   (input valid, input byte_in, input end_of_input, output ready);
endinterface

// File: hw/rtl/u8u16_out_if.sv
// ----------------------------------------------------------------------------
// u8u16_out_if
// Code unit request channel: one UTF-16 code unit with its flags.
// ----------------------------------------------------------------------------
interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        is_replacement;
  logic        last_of_run;

  modport source (output valid, output code_unit, output is_replacement,
                  output last_of_run, input ready);
  modport sink   (input valid, input code_unit, input is_replacement,
                  input last_of_run, output ready);
endinterface

// File: hw/rtl/u8u16_queue.sv
// ----------------------------------------------------------------------------
// u8u16_queue
// Small FIFO of run descriptors between the classifier and the emitter.
// ----------------------------------------------------------------------------
module u8u16_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  u8u16_pkg::run_desc_t  push_desc,
  input  logic                  pop,
  output u8u16_pkg::run_desc_t  head_desc,
  output u8u16_pkg::q_status_t  status
);

  u8u16_pkg::run_desc_t             mem_r [u8u16_pkg::QDEPTH];
  logic [u8u16_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [u8u16_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [u8u16_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? u8u16_pkg::QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? u8u16_pkg::QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = u8u16_pkg::QCNT_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = u8u16_pkg::QCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  assign head_desc    = mem_r[rd_ptr_r];
  assign status.full  = (cnt_r == u8u16_pkg::QCNT_W'(u8u16_pkg::QDEPTH));
  assign status.empty = (cnt_r == '0);

endmodule

// File: hw/rtl/u8u16_front.sv
// ----------------------------------------------------------------------------
// u8u16_front
// Classifier: takes one byte per cycle while the queue is not full, tracks
// the pending sequence and turns each byte into a run descriptor for the emitter.
// ----------------------------------------------------------------------------
module u8u16_front (
  input  logic                  clk,
  input  logic                  rst_n,
  u8u16_in_if.sink              in_ch,
  input  u8u16_pkg::q_status_t  q_status,
  output logic                  push,
  output u8u16_pkg::run_desc_t  push_desc
);

  logic [20:0] pv_r, pv_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [1:0]  taken_r, taken_nxt;

  logic        fire;
  logic        in_seq;
  logic        is_cont;
  logic [7:0]  b;
  logic        eoi;
  logic [20:0] pv_ext;
  logic [2:0]  taken_inc;
  logic [20:0] low_bound;
  logic        bad_cp;
  logic [19:0] cp_off;
  logic        do_fresh;
  logic [2:0]  n_repl;
  u8u16_pkg::tail_t tail;
  logic [15:0] unit0;
  logic [15:0] unit1;

  assign b       = in_ch.byte_in;
  assign eoi     = in_ch.end_of_input;
  assign fire    = in_ch.valid && in_ch.ready;
  assign is_cont = (b[7:6] == 2'b10);
  assign in_seq  = (len_r >= 3'd2) && (len_r <= 3'd4) && (taken_r != 2'd0) &&
                   ({1'b0, taken_r} < len_r);

  assign pv_ext    = {pv_r[14:0], b[5:0]};
  assign taken_inc = {1'b0, taken_r} + 3'd1;

  always_comb begin
    unique case (len_r)
      3'd2:    low_bound = 21'h000080;
      3'd3:    low_bound = 21'h000800;
      default: low_bound = 21'h010000;
    endcase
  end

  assign bad_cp = (pv_ext < low_bound) || (pv_ext > 21'h10FFFF) ||
                  ((pv_ext >= 21'h00D800) && (pv_ext <= 21'h00DFFF));
  assign cp_off = 20'(pv_ext - 21'h010000);

  always_comb begin
    pv_nxt    = pv_r;
    len_nxt   = len_r;
    taken_nxt = taken_r;
    n_repl    = 3'd0;
    tail      = u8u16_pkg::TAIL_NONE;
    unit0     = {8'h00, b};
    unit1     = 16'h0000;
    do_fresh  = 1'b0;

    if (in_seq && is_cont) begin
      if (taken_inc == len_r) begin
        pv_nxt    = '0;
        len_nxt   = '0;
        taken_nxt = '0;
        if (bad_cp) begin
          n_repl = len_r;
        end else if (pv_ext > 21'h00FFFF) begin
          tail  = u8u16_pkg::TAIL_PAIR;
          unit0 = 16'hD800 + {6'd0, cp_off[19:10]};
          unit1 = 16'hDC00 + {6'd0, cp_off[9:0]};
        end else begin
          tail  = u8u16_pkg::TAIL_ONE;
          unit0 = pv_ext[15:0];
        end
      end else if (eoi) begin
        // truncated at end of input: one replacement per byte taken
        pv_nxt    = '0;
        len_nxt   = '0;
        taken_nxt = '0;
        n_repl    = taken_inc;
      end else begin
        pv_nxt    = pv_ext;
        taken_nxt = taken_inc[1:0];
      end
    end else begin
      // broken sequence flushes what was buffered, then decode afresh
      pv_nxt    = '0;
      len_nxt   = '0;
      taken_nxt = '0;
      n_repl    = in_seq ? {1'b0, taken_r} : 3'd0;
      do_fresh  = 1'b1;
    end

    if (do_fresh) begin
      if (b[7] == 1'b0) begin
        tail = u8u16_pkg::TAIL_ONE;
      end else if ((b[7:5] == 3'b110) || (b[7:4] == 4'b1110) || (b[7:3] == 5'b11110)) begin
        if (eoi) begin
          n_repl = n_repl + 3'd1;
        end else begin
          taken_nxt = 2'd1;
          if (b[7:5] == 3'b110) begin
            pv_nxt  = {16'd0, b[4:0]};
            len_nxt = 3'd2;
          end else if (b[7:4] == 4'b1110) begin
            pv_nxt  = {17'd0, b[3:0]};
            len_nxt = 3'd3;
          end else begin
            pv_nxt  = {18'd0, b[2:0]};
            len_nxt = 3'd4;
          end
        end
      end else begin
        n_repl = n_repl + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r    <= '0;
      len_r   <= '0;
      taken_r <= '0;
    end else if (fire) begin
      pv_r    <= pv_nxt;
      len_r   <= len_nxt;
      taken_r <= taken_nxt;
    end
  end

  assign in_ch.ready      = !q_status.full;
  // bytes that only extend a sequence produce nothing to queue
  assign push             = fire && ((n_repl != 3'd0) || (tail != u8u16_pkg::TAIL_NONE));
  assign push_desc.n_repl = n_repl;
  assign push_desc.tail   = tail;
  assign push_desc.unit0  = unit0;
  assign push_desc.unit1  = unit1;

endmodule

// File: hw/rtl/u8u16_back.sv
// ----------------------------------------------------------------------------
// u8u16_back
// Emitter: expands the head run descriptor into code units, one per cycle while
// out_ch is ready and a descriptor is queued, through a registered output stage.
// ----------------------------------------------------------------------------
module u8u16_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  u8u16_pkg::run_desc_t  head_desc,
  input  u8u16_pkg::q_status_t  q_status,
  output logic                  pop,
  u8u16_out_if.source           out_ch
);

  logic [1:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] unit_r;
  logic        repl_r;
  logic        last_r;

  logic        load;
  logic        emit;
  logic        last;
  logic [2:0]  tail_cnt;
  logic [2:0]  total;
  logic [2:0]  idx_ext;
  logic [15:0] sel_unit;
  logic        sel_repl;

  always_comb begin
    unique case (head_desc.tail)
      u8u16_pkg::TAIL_ONE:  tail_cnt = 3'd1;
      u8u16_pkg::TAIL_PAIR: tail_cnt = 3'd2;
      default:              tail_cnt = 3'd0;
    endcase
  end

  assign total   = head_desc.n_repl + tail_cnt;
  assign idx_ext = {1'b0, idx_r};
  assign load    = !out_valid_r || out_ch.ready;
  assign emit    = load && !q_status.empty;
  assign last    = ((idx_ext + 3'd1) == total);
  assign pop     = emit && last;

  always_comb begin
    if (idx_ext < head_desc.n_repl) begin
      sel_unit = u8u16_pkg::REPL_UNIT;
      sel_repl = 1'b1;
    end else if (idx_ext == head_desc.n_repl) begin
      sel_unit = head_desc.unit0;
      sel_repl = 1'b0;
    end else begin
      sel_unit = head_desc.unit1;
      sel_repl = 1'b0;
    end
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      idx_nxt       = last ? 2'd0 : 2'(idx_r + 2'd1);
      out_valid_nxt = 1'b1;
    end else if (load) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      unit_r <= sel_unit;
      repl_r <= sel_repl;
      last_r <= last;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.code_unit      = unit_r;
  assign out_ch.is_replacement = repl_r;
  assign out_ch.last_of_run    = last_r;

endmodule

// File: hw/rtl/utf8_to_utf16_strict_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_strict_decoder_core
// Streaming UTF-8 to UTF-16 decoder; malformed input becomes U+FFFD.
// ----------------------------------------------------------------------------
//   port    dir  handshake      payload
//   in_ch   in   valid/ready    byte_in[7:0], end_of_input
//   out_ch  out  valid/ready    code_unit[15:0], is_replacement, last_of_run
//
// Takes one byte per cycle while the queue is not full; a byte yielding k code
// units keeps the emitter busy until all k are sent, one unit per cycle from its
// output register while out_ch is ready; a byte's descriptor is queued first.
// A 4-entry descriptor queue absorbs bursts; in_ch.ready drops only when full.
// rst_n (synchronous) clears the pending sequence, queue and output valid.
// ----------------------------------------------------------------------------
module utf8_to_utf16_strict_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  u8u16_in_if.sink    in_ch,
  u8u16_out_if.source out_ch
);

  logic                 push;
  logic                 pop;
  u8u16_pkg::run_desc_t push_desc;
  u8u16_pkg::run_desc_t head_desc;
  u8u16_pkg::q_status_t q_status;

  u8u16_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_status  (q_status),
    .push      (push),
    .push_desc (push_desc)
  );

  u8u16_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .status    (q_status)
  );

  u8u16_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_desc (head_desc),
    .q_status  (q_status),
    .pop       (pop),
    .out_ch    (out_ch)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!q_status.full || pop))
    else $error("descriptor pushed into a full queue");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> !q_status.empty)
    else $error("queue empty right after a push");

  a_repl_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.is_replacement) |-> (out_ch.code_unit == 16'hFFFD))
    else $error("replacement flag on a unit other than U+FFFD");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!q_status.empty))
    else $error("output valid without a queued descriptor");

endmodule
